>>> design/wps_pkg.sv
package wps_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int MAX_POINTS    = 65536;

    localparam int OPD_W   = 24;
    localparam int AMP_W   = 16;
    localparam int SCALE_W = 32;
    localparam int PHASE_W = 32;
    localparam int SUM_W   = 48;
    localparam int XY_W    = 20;
    localparam int Z_W     = 34;
    localparam int TRIG_W  = 16;
    localparam int PROD_W  = AMP_W + TRIG_W + 1;
    localparam int ITER_W  = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
    localparam int ATAN_IDX_W = 5;

    localparam logic signed [XY_W-1:0]   CORDIC_GAIN = XY_W'(19899);
    localparam logic signed [XY_W-1:0]   TRIG_LIMIT  = XY_W'(32767);
    localparam logic signed [SUM_W-1:0]  ACC_MAX     = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]  ACC_MIN     = {1'b1, {(SUM_W-1){1'b0}}};

    typedef logic [ITER_W-1:0] iter_t;

    typedef struct packed {
        logic  load;
        logic  setup;
        logic  rotate;
        logic  finish;
        logic  product;
        logic  accum;
        iter_t iter;
    } cmd_t;

    typedef struct packed {
        logic last_point;
    } status_t;

    // atan(2^-i) in turns, Q0.32
    function automatic logic [PHASE_W-1:0] atan_turns(input logic [ATAN_IDX_W-1:0] idx);
        logic [PHASE_W-1:0] val;
        case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051E;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2F;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2FA;
            5'd15:   val = 32'h0000517D;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A30;
            5'd19:   val = 32'h00000518;
            5'd20:   val = 32'h0000028C;
            5'd21:   val = 32'h00000146;
            5'd22:   val = 32'h000000A3;
            5'd23:   val = 32'h00000051;
            5'd24:   val = 32'h00000029;
            5'd25:   val = 32'h00000014;
            5'd26:   val = 32'h0000000A;
            5'd27:   val = 32'h00000005;
            5'd28:   val = 32'h00000003;
            5'd29:   val = 32'h00000001;
            5'd30:   val = 32'h00000001;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

>>> design/wps_if.sv
interface wps_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [wps_pkg::OPD_W-1:0]    opd_sample;
    logic        [wps_pkg::AMP_W-1:0]    amplitude;
    logic                                last_point;

    modport source (output valid, opd_sample, amplitude, last_point, input ready);
    modport sink   (input valid, opd_sample, amplitude, last_point, output ready);
endinterface

interface wps_sum_if;
    logic                                valid;
    logic                                ready;
    logic signed [wps_pkg::SUM_W-1:0]    sum_real;
    logic signed [wps_pkg::SUM_W-1:0]    sum_imag;

    modport source (output valid, sum_real, sum_imag, input ready);
    modport sink   (input valid, sum_real, sum_imag, output ready);
endinterface

>>> design/wps_ctrl.sv
module wps_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  wps_pkg::status_t status,
    output wps_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SETUP   = 3'd1;
    localparam logic [2:0] ST_ROTATE  = 3'd2;
    localparam logic [2:0] ST_FINISH  = 3'd3;
    localparam logic [2:0] ST_PRODUCT = 3'd4;
    localparam logic [2:0] ST_ACCUM   = 3'd5;

    localparam wps_pkg::iter_t ITER_LAST = wps_pkg::ITER_W'(wps_pkg::CORDIC_STAGES - 1);

    logic [2:0]     state_reg, state_next;
    wps_pkg::iter_t iter_reg, iter_next;
    logic           out_valid_reg, out_valid_next;
    logic           slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.iter       = iter_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                iter_next  = '0;
                state_next = ST_ROTATE;
            end
            ST_ROTATE:
            begin
                cmd.rotate = 1'b1;
                if (iter_reg == ITER_LAST)
                    state_next = ST_FINISH;
                else
                    iter_next = iter_reg + 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_PRODUCT;
            end
            ST_PRODUCT:
            begin
                cmd.product = 1'b1;
                state_next  = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                // a final point waits for the output slot
                if (!status.last_point || slot_free)
                begin
                    cmd.accum  = 1'b1;
                    state_next = ST_IDLE;
                    if (status.last_point)
                        out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> design/wps_datapath.sv
module wps_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic        [wps_pkg::SCALE_W-1:0]    cfg_wr_data,
    input  logic signed [wps_pkg::OPD_W-1:0]      opd_sample,
    input  logic        [wps_pkg::AMP_W-1:0]      amplitude,
    input  logic                                  last_point,
    input  wps_pkg::cmd_t                         cmd,
    output wps_pkg::status_t                      status,
    output logic signed [wps_pkg::SUM_W-1:0]      sum_real,
    output logic signed [wps_pkg::SUM_W-1:0]      sum_imag
);

    localparam int XY_W  = wps_pkg::XY_W;
    localparam int Z_W   = wps_pkg::Z_W;
    localparam int SUM_W = wps_pkg::SUM_W;

    logic        [wps_pkg::SCALE_W-1:0] phase_scale_reg;
    logic        [wps_pkg::PHASE_W-1:0] phase_reg;
    logic        [wps_pkg::AMP_W-1:0]   amp_reg;
    logic                               last_reg;
    logic                               fold_reg;
    logic signed [XY_W-1:0]             x_reg, y_reg;
    logic signed [Z_W-1:0]              z_reg;
    logic signed [wps_pkg::TRIG_W-1:0]  cos_reg, sin_reg;
    logic signed [wps_pkg::PROD_W-1:0]  prod_re_reg, prod_im_reg;
    logic signed [SUM_W-1:0]            acc_re_reg, acc_im_reg;
    logic signed [SUM_W-1:0]            sum_re_reg, sum_im_reg;

    logic        [wps_pkg::PHASE_W-1:0] opd_ext;
    logic        [wps_pkg::PHASE_W-1:0] phase_prod;
    logic                               fold;
    logic        [wps_pkg::PHASE_W-1:0] folded;
    logic signed [XY_W-1:0]             dx, dy;
    logic signed [Z_W-1:0]              atan_ext;
    logic signed [XY_W-1:0]             x_fin, y_fin;
    logic signed [XY_W-1:0]             cos_clamp, sin_clamp;
    logic signed [SUM_W:0]              sum_re_wide, sum_im_wide;
    logic signed [SUM_W-1:0]            sum_re_sat, sum_im_sat;

    function automatic logic signed [XY_W-1:0] clamp_trig(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] r;
        if (v > wps_pkg::TRIG_LIMIT)
            r = wps_pkg::TRIG_LIMIT;
        else if (v < -wps_pkg::TRIG_LIMIT)
            r = -wps_pkg::TRIG_LIMIT;
        else
            r = v;
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_acc(input logic signed [SUM_W:0] v);
        logic signed [SUM_W-1:0] r;
        if (v[SUM_W] != v[SUM_W-1])
            r = v[SUM_W] ? wps_pkg::ACC_MIN : wps_pkg::ACC_MAX;
        else
            r = v[SUM_W-1:0];
        return r;
    endfunction

    // low 32 bits of the signed opd times the unsigned scale
    assign opd_ext    = wps_pkg::PHASE_W'($unsigned(
                            {{(wps_pkg::PHASE_W-wps_pkg::OPD_W){opd_sample[wps_pkg::OPD_W-1]}},
                             opd_sample}));
    assign phase_prod = opd_ext * phase_scale_reg;

    // second and third quadrants fold back by half a turn
    assign fold   = phase_reg[wps_pkg::PHASE_W-1] ^ phase_reg[wps_pkg::PHASE_W-2];
    assign folded = fold ? (phase_reg ^ {1'b1, {(wps_pkg::PHASE_W-1){1'b0}}}) : phase_reg;

    assign dx       = y_reg >>> cmd.iter;
    assign dy       = x_reg >>> cmd.iter;
    assign atan_ext = $signed({{(Z_W-wps_pkg::PHASE_W){1'b0}},
                              wps_pkg::atan_turns(wps_pkg::ATAN_IDX_W'(cmd.iter))});

    assign x_fin     = fold_reg ? -x_reg : x_reg;
    assign y_fin     = fold_reg ? -y_reg : y_reg;
    assign cos_clamp = clamp_trig(x_fin);
    assign sin_clamp = clamp_trig(y_fin);

    assign sum_re_wide = {acc_re_reg[SUM_W-1], acc_re_reg}
                         + (SUM_W+1)'(prod_re_reg);
    assign sum_im_wide = {acc_im_reg[SUM_W-1], acc_im_reg}
                         + (SUM_W+1)'(prod_im_reg);
    assign sum_re_sat  = sat_acc(sum_re_wide);
    assign sum_im_sat  = sat_acc(sum_im_wide);

    assign status.last_point = last_reg;
    assign sum_real          = sum_re_reg;
    assign sum_imag          = sum_im_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_scale_reg <= '0;
            acc_re_reg      <= '0;
            acc_im_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                phase_scale_reg <= cfg_wr_data;
            if (cmd.accum)
            begin
                if (last_reg)
                begin
                    acc_re_reg <= '0;
                    acc_im_reg <= '0;
                end
                else
                begin
                    acc_re_reg <= sum_re_sat;
                    acc_im_reg <= sum_im_sat;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            phase_reg <= phase_prod;
            amp_reg   <= amplitude;
            last_reg  <= last_point;
        end
        if (cmd.setup)
        begin
            fold_reg <= fold;
            x_reg    <= wps_pkg::CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= $signed({{(Z_W-wps_pkg::PHASE_W){folded[wps_pkg::PHASE_W-1]}}, folded});
        end
        if (cmd.rotate)
        begin
            if (!z_reg[Z_W-1])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - atan_ext;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + atan_ext;
            end
        end
        if (cmd.finish)
        begin
            cos_reg <= wps_pkg::TRIG_W'(cos_clamp);
            sin_reg <= wps_pkg::TRIG_W'(sin_clamp);
        end
        if (cmd.product)
        begin
            prod_re_reg <= $signed({{(wps_pkg::PROD_W-wps_pkg::AMP_W){1'b0}}, amp_reg})
                           * $signed({{(wps_pkg::PROD_W-wps_pkg::TRIG_W){cos_reg[wps_pkg::TRIG_W-1]}},
                                      cos_reg});
            prod_im_reg <= $signed({{(wps_pkg::PROD_W-wps_pkg::AMP_W){1'b0}}, amp_reg})
                           * $signed({{(wps_pkg::PROD_W-wps_pkg::TRIG_W){sin_reg[wps_pkg::TRIG_W-1]}},
                                      sin_reg});
        end
        if (cmd.accum && last_reg)
        begin
            sum_re_reg <= sum_re_sat;
            sum_im_reg <= sum_im_sat;
        end
    end

endmodule

>>> design/weighted_phasor_sum.sv
// channel  | dir | payload                                  | note
// point    | in  | opd_sample, amplitude, last_point        | one pupil point per item
// result   | out | sum_real, sum_imag                       | one item per last_point
// cfg      | in  | cfg_wr_data (phase_scale)                | write when idle
//
// an item steps through accept with phase multiply, rotator setup, one shared cordic
// rotation per stage, then fold/clamp, multiply, accumulate
// the cordic rotation loop sets the rate; only one item is in flight at a time
// rst_n clears the accumulators, phase_scale, sequencer state and result valid
// a finished result sits in its output register and the next point is taken meanwhile;
// only a final point whose result cannot yet be stored waits in the accumulate step
module weighted_phasor_sum (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [wps_pkg::SCALE_W-1:0]       cfg_wr_data,
    wps_point_if.sink                         point,
    wps_sum_if.source                         result
);

    wps_pkg::cmd_t    cmd;
    wps_pkg::status_t status;

    // sequencer: steps the rotator and owns the result valid flag
    wps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (point.valid),
        .in_ready  (point.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // phase multiply, cordic rotator, weighting and saturating accumulators
    wps_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .opd_sample  (point.opd_sample),
        .amplitude   (point.amplitude),
        .last_point  (point.last_point),
        .cmd         (cmd),
        .status      (status),
        .sum_real    (result.sum_real),
        .sum_imag    (result.sum_imag)
    );

    // an accepted point keeps the block busy for the following cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        point.valid && point.ready |=> !point.ready)
        else $error("point accepted while previous still loading");

    // a result appears only from accumulating a final point
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(cmd.accum && status.last_point))
        else $error("result valid without final point");

    // the last rotation stage hands over to the fold and clamp step
    a_rotate_exit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rotate && (cmd.iter == wps_pkg::ITER_W'(wps_pkg::CORDIC_STAGES - 1))
        |=> cmd.finish)
        else $error("cordic did not finish after last stage");

    // a final point never overwrites a result still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accum && status.last_point |-> !result.valid || result.ready)
        else $error("result overwritten");

endmodule
